FILE: rtl/sspc_pkg.sv
`timescale 1ns / 1ps

package sspc_pkg;

   localparam int OP_W    = 2;
   localparam int ADDR_W  = 4;
   localparam int WDATA_W = 16;
   localparam int RDATA_W = 32;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   localparam logic [ADDR_W-1:0] ADDR_DATA    = 4'h0;
   localparam logic [ADDR_W-1:0] ADDR_STATUS  = 4'h4;
   localparam logic [ADDR_W-1:0] ADDR_MODE    = 4'h8;
   localparam logic [ADDR_W-1:0] ADDR_CONTROL = 4'hA;
   localparam logic [ADDR_W-1:0] ADDR_BAUD    = 4'hE;

   localparam logic [7:0]  BIT_PERIOD     = 8'd68;
   localparam logic [5:0]  ACK_HOLD_TICKS = 6'd32;

   localparam logic [15:0] CONTROL_MASK = 16'h3F2F;
   localparam logic [15:0] MODE_MASK    = 16'h013F;

   localparam int CTRL_TX_EN     = 0;
   localparam int CTRL_DTR       = 1;
   localparam int CTRL_RX_EN     = 2;
   localparam int CTRL_IRQ_ACK   = 4;
   localparam int CTRL_RESET     = 6;
   localparam int CTRL_IRQ_TX    = 10;
   localparam int CTRL_IRQ_RX    = 11;
   localparam int CTRL_IRQ_DSR   = 12;
   localparam int CTRL_PORT_SEL  = 13;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [ADDR_W-1:0]  addr;
      logic [WDATA_W-1:0] wdata;
      logic               rxd;
      logic               dsr_pulse;
   } item_type;

   typedef struct packed {
      logic [RDATA_W-1:0] rdata;
      logic               txd;
      logic               bit_strobe;
      logic               select_port0;
      logic               select_port1;
      logic               irq;
   } result_type;

endpackage

FILE: rtl/sspc_if.sv
`timescale 1ns / 1ps

interface sspc_req_if;
   logic                         valid;
   logic                         ready;
   logic [sspc_pkg::OP_W-1:0]    op;
   logic [sspc_pkg::ADDR_W-1:0]  addr;
   logic [sspc_pkg::WDATA_W-1:0] wdata;
   logic                         rxd;
   logic                         dsr_pulse;

   modport source (output valid, op, addr, wdata, rxd, dsr_pulse, input ready);
   modport sink   (input valid, op, addr, wdata, rxd, dsr_pulse, output ready);
endinterface

interface sspc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sspc_pkg::RDATA_W-1:0] rdata;
   logic                         txd;
   logic                         bit_strobe;
   logic                         select_port0;
   logic                         select_port1;
   logic                         irq;

   modport source (output valid, rdata, txd, bit_strobe, select_port0, select_port1, irq,
                   input ready);
   modport sink   (input valid, rdata, txd, bit_strobe, select_port0, select_port1, irq,
                   output ready);
endinterface

FILE: rtl/sspc_core.sv
`timescale 1ns / 1ps

module sspc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  sspc_pkg::item_type   item,
   output sspc_pkg::result_type res
);

   typedef struct packed {
      logic [15:0] control;
      logic [8:0]  mode;
      logic [15:0] baud;
      logic [7:0]  tx_byte;
      logic [7:0]  rx_byte;
      logic        tx_pending;
      logic        rx_pending;
      logic        tx_busy;
      logic        rx_busy;
      logic        rx_ready;
      logic [2:0]  tx_bit_index;
      logic [2:0]  rx_bit_index;
      logic [7:0]  period_count;
      logic        irq_flag;
      logic [5:0]  ack_hold;
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      done;

   function automatic state_type start_check(input state_type s);
      state_type r;
      logic      go;
      r  = s;
      go = (r.rx_pending && r.control[sspc_pkg::CTRL_RX_EN]) ||
           (r.tx_pending && r.control[sspc_pkg::CTRL_TX_EN]);
      if (go) begin
         if (r.rx_pending) begin
            r.rx_pending   = 1'b0;
            r.rx_busy      = 1'b1;
            r.rx_ready     = 1'b0;
            r.rx_byte      = '0;
            r.rx_bit_index = '0;
         end
         if (r.tx_pending) begin
            r.tx_pending   = 1'b0;
            r.tx_busy      = 1'b1;
            r.tx_bit_index = '0;
         end
         r.period_count = sspc_pkg::BIT_PERIOD;
      end
      if (!r.control[sspc_pkg::CTRL_TX_EN] && !r.control[sspc_pkg::CTRL_RX_EN]) begin
         r.rx_busy = 1'b0;
         r.tx_busy = 1'b0;
      end
      if (!r.rx_busy && !r.tx_busy) begin
         r.period_count = '0;
      end
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      res      = '0;
      done     = 1'b0;
      unique case (item.op)
         sspc_pkg::OP_TICK: begin
            if (item.dsr_pulse && state_in.control[sspc_pkg::CTRL_DTR]) begin
               state_in.ack_hold = sspc_pkg::ACK_HOLD_TICKS;
               if (state_in.control[sspc_pkg::CTRL_IRQ_DSR]) begin
                  state_in.irq_flag = 1'b1;
               end
            end else if (state_in.ack_hold != '0) begin
               state_in.ack_hold = state_in.ack_hold - 6'd1;
            end
            if (state_in.period_count != '0) begin
               state_in.period_count = state_in.period_count - 8'd1;
               if (state_in.period_count == '0 && (state_in.rx_busy || state_in.tx_busy)) begin
                  res.bit_strobe = 1'b1;
                  if (state_in.tx_busy) begin
                     res.txd = state_in.tx_byte[state_in.tx_bit_index];
                     state_in.tx_bit_index = state_in.tx_bit_index + 3'd1;
                     if (state_in.tx_bit_index == '0) begin
                        done             = 1'b1;
                        state_in.tx_busy = 1'b0;
                        if (state_in.control[sspc_pkg::CTRL_IRQ_TX]) begin
                           state_in.irq_flag = 1'b1;
                        end
                     end
                  end
                  if (state_in.rx_busy) begin
                     state_in.rx_byte[state_in.rx_bit_index] = item.rxd;
                     state_in.rx_bit_index = state_in.rx_bit_index + 3'd1;
                     if (state_in.rx_bit_index == '0) begin
                        done              = 1'b1;
                        state_in.rx_busy  = 1'b0;
                        state_in.rx_ready = 1'b1;
                        if (state_in.control[sspc_pkg::CTRL_IRQ_RX]) begin
                           state_in.irq_flag = 1'b1;
                        end
                     end
                  end
                  state_in.period_count = sspc_pkg::BIT_PERIOD;
                  if (done) begin
                     state_in = start_check(state_in);
                  end
                  if (!state_in.rx_busy && !state_in.tx_busy) begin
                     state_in.period_count = '0;
                  end
               end
            end
         end
         sspc_pkg::OP_READ: begin
            unique case (item.addr)
               sspc_pkg::ADDR_DATA: begin
                  res.rdata         = {4{state_in.rx_byte}};
                  state_in.rx_ready   = 1'b0;
                  state_in.rx_pending = 1'b1;
                  state_in.rx_busy    = 1'b0;
                  state_in            = start_check(state_in);
               end
               sspc_pkg::ADDR_STATUS: begin
                  res.rdata[0] = !state_in.tx_pending && !state_in.tx_busy;
                  res.rdata[1] = state_in.rx_ready;
                  res.rdata[7] = state_in.ack_hold != '0;
                  res.rdata[9] = state_in.irq_flag;
               end
               sspc_pkg::ADDR_MODE:    res.rdata = {23'd0, state_in.mode};
               sspc_pkg::ADDR_CONTROL: res.rdata = {16'd0, state_in.control};
               sspc_pkg::ADDR_BAUD:    res.rdata = {16'd0, state_in.baud};
               default: ;
            endcase
         end
         sspc_pkg::OP_WRITE: begin
            unique case (item.addr)
               sspc_pkg::ADDR_DATA: begin
                  state_in.tx_byte    = item.wdata[7:0];
                  state_in.tx_pending = 1'b1;
                  state_in.tx_busy    = 1'b0;
               end
               sspc_pkg::ADDR_MODE: begin
                  state_in.mode = item.wdata[8:0] & sspc_pkg::MODE_MASK[8:0];
               end
               sspc_pkg::ADDR_CONTROL: begin
                  if (item.wdata[sspc_pkg::CTRL_RESET]) begin
                     state_in = '0;
                  end else begin
                     state_in.control = item.wdata & sspc_pkg::CONTROL_MASK;
                     if (item.wdata[sspc_pkg::CTRL_IRQ_ACK]) begin
                        state_in.irq_flag = 1'b0;
                     end
                     if (!state_in.control[sspc_pkg::CTRL_DTR] ||
                         (state_in.control[sspc_pkg::CTRL_PORT_SEL] !=
                          state_ff.control[sspc_pkg::CTRL_PORT_SEL])) begin
                        state_in.ack_hold = '0;
                     end
                  end
               end
               sspc_pkg::ADDR_BAUD: state_in.baud = item.wdata;
               default: ;
            endcase
            state_in = start_check(state_in);
         end
         default: ;
      endcase
      res.select_port0 = state_in.control[sspc_pkg::CTRL_DTR] &&
                         !state_in.control[sspc_pkg::CTRL_PORT_SEL];
      res.select_port1 = state_in.control[sspc_pkg::CTRL_DTR] &&
                         state_in.control[sspc_pkg::CTRL_PORT_SEL];
      res.irq          = state_in.irq_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/sync_serial_port_controller_top.sv
// Synchronous serial port controller.
// req_chan carries one request per handshake: a clock tick, a register read
// or a register write (op, addr, wdata, plus rxd and dsr_pulse for ticks).
// rsp_chan returns exactly one response per request, in order: read data,
// the transmit bit and bit strobe of a tick, the two port select lines and
// the interrupt level as they stand after the request.
// A request is held in the input register, then the port state and the
// response register update together. One request is accepted every cycle
// while the response side takes responses; all per-request work is a single
// short combinational pass over the port state, so nothing iterates.
// When rsp_chan stalls, the response register holds and the input register
// absorbs one more request before req_chan.ready drops.
// Synchronous reset clears the registers, flags, divider and hold window,
// and empties both pipeline registers.
`timescale 1ns / 1ps

module sync_serial_port_controller_top (
   input logic        clock,
   input logic        reset,
   sspc_req_if.sink   req_chan,
   sspc_rsp_if.source rsp_chan
);

   logic                 s1_valid_ff;
   sspc_pkg::item_type   s1_item_ff;
   logic                 out_valid_ff;
   sspc_pkg::result_type out_res_ff;
   sspc_pkg::result_type core_res;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.op        <= req_chan.op;
         s1_item_ff.addr      <= req_chan.addr;
         s1_item_ff.wdata     <= req_chan.wdata;
         s1_item_ff.rxd       <= req_chan.rxd;
         s1_item_ff.dsr_pulse <= req_chan.dsr_pulse;
      end
   end

   sspc_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (s1_item_ff),
      .res   (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.rdata        = out_res_ff.rdata;
   assign rsp_chan.txd          = out_res_ff.txd;
   assign rsp_chan.bit_strobe   = out_res_ff.bit_strobe;
   assign rsp_chan.select_port0 = out_res_ff.select_port0;
   assign rsp_chan.select_port1 = out_res_ff.select_port1;
   assign rsp_chan.irq          = out_res_ff.irq;

   a_no_dual_select: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.select_port0 && rsp_chan.select_port1))
      else $error("both port selects active");

   a_txd_needs_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (!rsp_chan.txd || rsp_chan.bit_strobe))
      else $error("txd high without bit strobe");

   a_strobe_no_rdata: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.bit_strobe) |-> (rsp_chan.rdata == '0))
      else $error("bit strobe on a read response");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && req_chan.ready))
      else $error("pipeline not empty after reset");

endmodule

FILE: test/sync_serial_port_controller_top_tb.sv
`timescale 1ns / 1ps

module sync_serial_port_controller_top_tb;

   localparam int TOTAL_REQUESTS = 1375;
   localparam int QUIET_FROM     = 1180;
   localparam int HOLD_AT        = 300;
   localparam int LONG_HOLD      = 250;
   localparam int CYCLE_LIMIT    = 300000;
   localparam int DRAIN_CYCLES   = 8;

   localparam int ST_TX_IDLE  = 0;
   localparam int ST_RX_READY = 1;
   localparam int ST_ACK_HOLD = 7;
   localparam int ST_IRQ      = 9;

   localparam logic [sspc_pkg::ADDR_W-1:0] ADDR_UNUSED_LO = 4'h1;
   localparam logic [sspc_pkg::ADDR_W-1:0] ADDR_UNUSED_HI = 4'hF;

   localparam logic [15:0] C_TX_EN    = 16'h1 << sspc_pkg::CTRL_TX_EN;
   localparam logic [15:0] C_DTR      = 16'h1 << sspc_pkg::CTRL_DTR;
   localparam logic [15:0] C_RX_EN    = 16'h1 << sspc_pkg::CTRL_RX_EN;
   localparam logic [15:0] C_IRQ_ACK  = 16'h1 << sspc_pkg::CTRL_IRQ_ACK;
   localparam logic [15:0] C_RESET    = 16'h1 << sspc_pkg::CTRL_RESET;
   localparam logic [15:0] C_IRQ_TX   = 16'h1 << sspc_pkg::CTRL_IRQ_TX;
   localparam logic [15:0] C_IRQ_RX   = 16'h1 << sspc_pkg::CTRL_IRQ_RX;
   localparam logic [15:0] C_IRQ_DSR  = 16'h1 << sspc_pkg::CTRL_IRQ_DSR;
   localparam logic [15:0] C_PORT_SEL = 16'h1 << sspc_pkg::CTRL_PORT_SEL;

   class serial_port_scoreboard;
      logic [15:0] control_q;
      logic [8:0]  mode_q;
      logic [15:0] baud_q;
      logic [7:0]  tx_byte;
      logic [7:0]  rx_byte;
      bit          tx_pend;
      bit          rx_pend;
      bit          tx_busy;
      bit          rx_busy;
      bit          rx_ready;
      bit [2:0]    tx_idx;
      bit [2:0]    rx_idx;
      bit [7:0]    divider;
      bit          irq_q;
      bit [5:0]    hold_q;
      sspc_pkg::result_type due_responses[$];
      int          mismatches;
      int          checked;
      int          bytes_received;
      int          ack_pulses;

      function new();
         clear_port();
         mismatches     = 0;
         checked        = 0;
         bytes_received = 0;
         ack_pulses     = 0;
      endfunction

      function void clear_port();
         control_q = '0;
         mode_q    = '0;
         baud_q    = '0;
         tx_byte   = '0;
         rx_byte   = '0;
         tx_pend   = 1'b0;
         rx_pend   = 1'b0;
         tx_busy   = 1'b0;
         rx_busy   = 1'b0;
         rx_ready  = 1'b0;
         tx_idx    = '0;
         rx_idx    = '0;
         divider   = '0;
         irq_q     = 1'b0;
         hold_q    = '0;
      endfunction

      function void try_start();
         bit go;
         go = (rx_pend && control_q[sspc_pkg::CTRL_RX_EN]) ||
              (tx_pend && control_q[sspc_pkg::CTRL_TX_EN]);
         if (go) begin
            if (rx_pend) begin
               rx_pend  = 1'b0;
               rx_busy  = 1'b1;
               rx_ready = 1'b0;
               rx_byte  = '0;
               rx_idx   = '0;
            end
            if (tx_pend) begin
               tx_pend = 1'b0;
               tx_busy = 1'b1;
               tx_idx  = '0;
            end
            divider = sspc_pkg::BIT_PERIOD;
         end
         if (!control_q[sspc_pkg::CTRL_TX_EN] && !control_q[sspc_pkg::CTRL_RX_EN]) begin
            rx_busy = 1'b0;
            tx_busy = 1'b0;
         end
         if (!rx_busy && !tx_busy)
            divider = '0;
      endfunction

      function sspc_pkg::result_type advance_port(sspc_pkg::item_type it);
         sspc_pkg::result_type r;
         bit                   done;
         logic [15:0]          old_ctrl;
         r = '0;
         case (it.op)
            sspc_pkg::OP_TICK: begin
               if (it.dsr_pulse && control_q[sspc_pkg::CTRL_DTR]) begin
                  hold_q = sspc_pkg::ACK_HOLD_TICKS;
                  ack_pulses++;
                  if (control_q[sspc_pkg::CTRL_IRQ_DSR])
                     irq_q = 1'b1;
               end else if (hold_q > 0) begin
                  hold_q--;
               end
               if (divider > 0) begin
                  divider--;
                  if (divider == 0 && (rx_busy || tx_busy)) begin
                     done         = 1'b0;
                     r.bit_strobe = 1'b1;
                     if (tx_busy) begin
                        r.txd  = tx_byte[tx_idx];
                        tx_idx = tx_idx + 3'd1;
                        if (tx_idx == 0) begin
                           done    = 1'b1;
                           tx_busy = 1'b0;
                           if (control_q[sspc_pkg::CTRL_IRQ_TX])
                              irq_q = 1'b1;
                        end
                     end
                     if (rx_busy) begin
                        rx_byte[rx_idx] = it.rxd;
                        rx_idx = rx_idx + 3'd1;
                        if (rx_idx == 0) begin
                           done     = 1'b1;
                           rx_busy  = 1'b0;
                           rx_ready = 1'b1;
                           bytes_received++;
                           if (control_q[sspc_pkg::CTRL_IRQ_RX])
                              irq_q = 1'b1;
                        end
                     end
                     divider = sspc_pkg::BIT_PERIOD;
                     if (done)
                        try_start();
                     if (!rx_busy && !tx_busy)
                        divider = '0;
                  end
               end
            end
            sspc_pkg::OP_READ: begin
               case (it.addr)
                  sspc_pkg::ADDR_DATA: begin
                     r.rdata  = {4{rx_byte}};
                     rx_ready = 1'b0;
                     rx_pend  = 1'b1;
                     rx_busy  = 1'b0;
                     try_start();
                  end
                  sspc_pkg::ADDR_STATUS: begin
                     r.rdata[ST_TX_IDLE]  = !tx_pend && !tx_busy;
                     r.rdata[ST_RX_READY] = rx_ready;
                     r.rdata[ST_ACK_HOLD] = hold_q > 0;
                     r.rdata[ST_IRQ]      = irq_q;
                  end
                  sspc_pkg::ADDR_MODE:    r.rdata = 32'(mode_q);
                  sspc_pkg::ADDR_CONTROL: r.rdata = 32'(control_q);
                  sspc_pkg::ADDR_BAUD:    r.rdata = 32'(baud_q);
                  default: ;
               endcase
            end
            sspc_pkg::OP_WRITE: begin
               case (it.addr)
                  sspc_pkg::ADDR_DATA: begin
                     tx_byte = it.wdata[7:0];
                     tx_pend = 1'b1;
                     tx_busy = 1'b0;
                  end
                  sspc_pkg::ADDR_MODE: mode_q = it.wdata[8:0] & sspc_pkg::MODE_MASK[8:0];
                  sspc_pkg::ADDR_CONTROL: begin
                     old_ctrl  = control_q;
                     control_q = it.wdata & sspc_pkg::CONTROL_MASK;
                     if (it.wdata[sspc_pkg::CTRL_IRQ_ACK])
                        irq_q = 1'b0;
                     if (it.wdata[sspc_pkg::CTRL_RESET])
                        clear_port();
                     if (!control_q[sspc_pkg::CTRL_DTR] ||
                         (control_q[sspc_pkg::CTRL_PORT_SEL] !=
                          old_ctrl[sspc_pkg::CTRL_PORT_SEL]))
                        hold_q = '0;
                  end
                  sspc_pkg::ADDR_BAUD: baud_q = it.wdata;
                  default: ;
               endcase
               try_start();
            end
            default: ;
         endcase
         r.select_port0 = control_q[sspc_pkg::CTRL_DTR] &&
                          !control_q[sspc_pkg::CTRL_PORT_SEL];
         r.select_port1 = control_q[sspc_pkg::CTRL_DTR] &&
                          control_q[sspc_pkg::CTRL_PORT_SEL];
         r.irq          = irq_q;
         return r;
      endfunction

      function void note_request(sspc_pkg::item_type it);
         due_responses.push_back(advance_port(it));
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(sspc_pkg::result_type got);
         sspc_pkg::result_type want;
         if (due_responses.size() == 0) begin
            $error("response with nothing outstanding: rdata %0h", got.rdata);
            mismatches++;
            return;
         end
         want = due_responses.pop_front();
         checked++;
         compare_field("rdata", want.rdata, got.rdata);
         compare_field("txd", want.txd, got.txd);
         compare_field("bit_strobe", want.bit_strobe, got.bit_strobe);
         compare_field("select_port0", want.select_port0, got.select_port0);
         compare_field("select_port1", want.select_port1, got.select_port1);
         compare_field("irq", want.irq, got.irq);
      endfunction

      function int outstanding();
         return due_responses.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   requests_sent = 0;
   int   cycle_count = 0;
   bit   long_hold_done = 1'b0;

   serial_port_scoreboard sb = new();

   sspc_req_if req_chan ();
   sspc_rsp_if rsp_chan ();

   sync_serial_port_controller_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sync_serial_port_controller_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin : watch_rsp
      sspc_pkg::result_type seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.rdata        = rsp_chan.rdata;
         seen.txd          = rsp_chan.txd;
         seen.bit_strobe   = rsp_chan.bit_strobe;
         seen.select_port0 = rsp_chan.select_port0;
         seen.select_port1 = rsp_chan.select_port1;
         seen.irq          = rsp_chan.irq;
         sb.check_response(seen);
      end
   end

   // throttle the response side; one long hold lets the block back up
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else if (!long_hold_done && requests_sent >= HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            rsp_chan.ready = 1'b0;
         end else if (requests_sent < QUIET_FROM && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [sspc_pkg::OP_W-1:0] op,
                               input logic [sspc_pkg::ADDR_W-1:0] addr,
                               input logic [sspc_pkg::WDATA_W-1:0] wdata, input logic rxd,
                               input logic dsr);
      sspc_pkg::item_type it;
      int                 gap;
      it.op        = op;
      it.addr      = addr;
      it.wdata     = wdata;
      it.rxd       = rxd;
      it.dsr_pulse = dsr;
      if (requests_sent < QUIET_FROM && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 17);
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.op        = it.op;
      req_chan.addr      = it.addr;
      req_chan.wdata     = it.wdata;
      req_chan.rxd       = it.rxd;
      req_chan.dsr_pulse = it.dsr_pulse;
      do
         @(posedge clock);
      while (!req_chan.ready);
      sb.note_request(it);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick(input logic rxd, input logic dsr);
      send_request(sspc_pkg::OP_TICK, sspc_pkg::ADDR_DATA, 16'($urandom), rxd, dsr);
   endtask

   task automatic run_directed();
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_STATUS, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_MODE, 16'hFFFF, 1'b1, 1'b1);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_MODE, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_BAUD, 16'hFFFF, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_BAUD, 16'h0000, 1'b0, 1'b0);
      // all control bits at once: the reset action wipes everything
      send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_CONTROL, 16'hFFFF, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_BAUD, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_CONTROL,
                   C_TX_EN | C_DTR | C_RX_EN | C_IRQ_TX | C_IRQ_RX | C_IRQ_DSR,
                   1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_STATUS, 16'h0000, 1'b0, 1'b0);
      // flip port select and clear the interrupt: hold window drops
      send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_CONTROL,
                   C_TX_EN | C_DTR | C_RX_EN | C_IRQ_TX | C_IRQ_RX | C_IRQ_DSR |
                   C_PORT_SEL | C_IRQ_ACK, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_STATUS, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_DATA, 16'hFFA5, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_DATA, 16'h0000, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_CONTROL, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_WRITE, ADDR_UNUSED_HI, 16'hFFFF, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, ADDR_UNUSED_LO, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, ADDR_UNUSED_HI, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_CONTROL, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_STATUS, 16'h0000, 1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_BAUD, 16'h0000, 1'b0, 1'b0);
      send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_BAUD, 16'h0000, 1'b0, 1'b0);
   endtask

   task automatic run_random_traffic();
      logic [15:0]                 ctrl;
      logic [sspc_pkg::ADDR_W-1:0] wr_addr;
      logic [sspc_pkg::ADDR_W-1:0] rd_addr;
      int                          run_len;
      int                          pick;
      while (requests_sent < TOTAL_REQUESTS) begin
         ctrl = 16'($urandom);
         if ($urandom_range(0, 15) != 0)
            ctrl &= ~C_RESET;
         if ($urandom_range(0, 3) != 0)
            ctrl |= C_TX_EN | C_RX_EN | C_DTR;
         send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_CONTROL, ctrl, 1'($urandom),
                      1'($urandom));
         if ($urandom_range(0, 3) != 0)
            send_request(sspc_pkg::OP_WRITE, sspc_pkg::ADDR_DATA, 16'($urandom),
                         1'($urandom), 1'($urandom));
         if ($urandom_range(0, 3) != 0)
            send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_DATA, 16'($urandom),
                         1'($urandom), 1'($urandom));
         run_len = ($urandom_range(0, 2) != 0) ? $urandom_range(550, 620)
                                               : $urandom_range(1, 120);
         if (run_len > TOTAL_REQUESTS - requests_sent)
            run_len = TOTAL_REQUESTS - requests_sent;
         if (run_len < 1)
            run_len = 1;
         repeat (run_len) begin
            pick    = $urandom_range(0, 39);
            rd_addr = 4'($urandom_range(0, 15));
            wr_addr = 4'($urandom_range(0, 15));
            if (wr_addr == sspc_pkg::ADDR_DATA || wr_addr == sspc_pkg::ADDR_CONTROL)
               wr_addr = sspc_pkg::ADDR_BAUD;
            case (pick)
               0: send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_STATUS, 16'($urandom),
                               1'($urandom), 1'($urandom));
               1: send_request(sspc_pkg::OP_READ, rd_addr, 16'($urandom), 1'($urandom),
                               1'($urandom));
               2: send_request(sspc_pkg::OP_WRITE, wr_addr, 16'($urandom), 1'($urandom),
                               1'($urandom));
               default: send_tick(1'($urandom), $urandom_range(0, 49) == 0);
            endcase
         end
         send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_STATUS, 16'($urandom),
                      1'($urandom), 1'($urandom));
         send_request(sspc_pkg::OP_READ, sspc_pkg::ADDR_DATA, 16'($urandom),
                      1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.op        = sspc_pkg::OP_TICK;
      req_chan.addr      = sspc_pkg::ADDR_DATA;
      req_chan.wdata     = '0;
      req_chan.rxd       = 1'b0;
      req_chan.dsr_pulse = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      run_random_traffic();
      req_chan.valid = 1'b0;
      while (sb.outstanding() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d responses: %0d bytes received, %0d acks seen",
               requests_sent, sb.checked, sb.bytes_received, sb.ack_pulses);
      $display("mismatches: %0d", sb.mismatches);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("sync_serial_port_controller_top regression: pass");
      else
         $display("sync_serial_port_controller_top regression: fail");
      $finish;
   end

endmodule
